/* hdl/dtps_pkg.sv */
// Shared types and constants for the tick-delay priority scheduler.
// Used by dtps_wait_bank and delay_tick_priority_scheduler; no dependencies.
package dtps_pkg;

    localparam int NUM_TASKS_DEF = 8;

    // Fixed payload widths
    localparam int OP_W      = 2;
    localparam int TICKS_W   = 16;
    localparam int TASK_ID_W = 3;
    localparam int RUN_W     = 4;
    localparam int MASK_W    = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELAY = 2'd1;
    localparam logic [OP_W-1:0] OP_READY = 2'd2;
    localparam logic [OP_W-1:0] OP_SCHED = 2'd3;

    // Command to the wait counter bank
    typedef struct packed {
        logic               tick;       // decrement the addressed counter if nonzero
        logic               load;       // load the counter of the running task
        logic [TICKS_W-1:0] load_data;
    } dtps_cmd_t;

endpackage

/* hdl/dtps_wait_bank.sv */
// Wait counter bank: one 16-bit counter per task and the shared decrement unit.
// Depends on dtps_pkg.
module dtps_wait_bank #(
    parameter int NUM_TASKS = dtps_pkg::NUM_TASKS_DEF,
    parameter int IW        = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [IW-1:0]       walk_idx,
    input  logic [IW-1:0]       load_idx,
    input  dtps_pkg::dtps_cmd_t cmd,
    output logic                zero_hit
);
    import dtps_pkg::*;

    logic [TICKS_W-1:0] cnt_reg [NUM_TASKS];
    logic [TICKS_W-1:0] cur_cnt;
    logic [TICKS_W-1:0] cnt_next;
    logic               cnt_nonzero;

    // Shared decrement unit on the walked counter
    assign cur_cnt     = cnt_reg[walk_idx];
    assign cnt_nonzero = (cur_cnt != '0);
    assign cnt_next    = cur_cnt - TICKS_W'(1);
    assign zero_hit    = cmd.tick && cnt_nonzero && (cnt_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            cnt_reg[load_idx] <= cmd.load_data;
        end else if (cmd.tick && cnt_nonzero) begin
            cnt_reg[walk_idx] <= cnt_next;
        end
    end

endmodule

/* hdl/delay_tick_priority_scheduler.sv */
// Tick-delay priority scheduler. A ready op or a zero delay goes straight to the
// result stage; a tick first walks every task counter; delay or schedule first
// scan the ready bits (the ready-bit scan stops at the first ready task).
// One item at a time; the next transfer is taken in the cycle after the result is
// loaded. Tick walks one counter per cycle through the shared decrementer.
// Synchronous active-low reset clears ready bits and counters, selects idle.
module delay_tick_priority_scheduler #(
    parameter int NUM_TASKS = dtps_pkg::NUM_TASKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dtps_pkg::OP_W-1:0]       s_op,
    input  logic [dtps_pkg::TICKS_W-1:0]    s_delay_ticks,
    input  logic [dtps_pkg::TASK_ID_W-1:0]  s_task_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dtps_pkg::RUN_W-1:0]      m_running_task,
    output logic [dtps_pkg::MASK_W-1:0]     m_ready_mask
);
    import dtps_pkg::*;

    localparam int TW = $clog2(NUM_TASKS + 1);
    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [TW-1:0] IDLE_TASK = TW'(NUM_TASKS);
    localparam logic [TW-1:0] LAST_IDX  = TW'(NUM_TASKS - 1);

    logic [1:0]           state_reg, state_next;
    logic [TW-1:0]        idx_reg, idx_next;
    logic [TW-1:0]        cur_reg, cur_next;
    logic [NUM_TASKS-1:0] ready_reg, ready_next;
    logic                 m_valid_reg, m_valid_next;
    logic [RUN_W-1:0]     run_out_reg, run_out_next;
    logic [MASK_W-1:0]    mask_out_reg, mask_out_next;

    dtps_cmd_t            cmd;
    logic                 zero_hit;
    logic [TW+2:0]        id_ext;
    logic [TW+RUN_W-1:0]  cur_wide;
    logic [NUM_TASKS+MASK_W-1:0] mask_wide;

    assign id_ext    = {{TW{1'b0}}, s_task_id};
    assign cur_wide  = {{RUN_W{1'b0}}, cur_reg};
    assign mask_wide = {{MASK_W{1'b0}}, ready_reg};

    dtps_wait_bank #(
        .NUM_TASKS (NUM_TASKS),
        .IW        (IW)
    ) u_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .walk_idx (idx_reg[IW-1:0]),
        .load_idx (cur_reg[IW-1:0]),
        .cmd      (cmd),
        .zero_hit (zero_hit)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_running_task = run_out_reg;
    assign m_ready_mask   = mask_out_reg;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        ready_next    = ready_reg;
        m_valid_next  = m_valid_reg;
        run_out_next  = run_out_reg;
        mask_out_next = mask_out_reg;
        cmd           = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                    case (s_op)
                        OP_TICK: begin
                            state_next = ST_TICK;
                        end
                        OP_DELAY: begin
                            if (s_delay_ticks != '0) begin
                                // park the running task, then rescan
                                if (cur_reg < IDLE_TASK) begin
                                    ready_next[cur_reg[IW-1:0]] = 1'b0;
                                    cmd.load      = 1'b1;
                                    cmd.load_data = s_delay_ticks;
                                end
                                state_next = ST_PICK;
                            end
                        end
                        OP_READY: begin
                            if (id_ext < (TW+3)'(NUM_TASKS)) begin
                                ready_next[id_ext[IW-1:0]] = 1'b1;
                            end
                        end
                        OP_SCHED: begin
                            state_next = ST_PICK;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                cmd.tick = 1'b1;
                if (zero_hit) begin
                    ready_next[idx_reg[IW-1:0]] = 1'b1;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + TW'(1);
                end
            end
            ST_PICK: begin
                // stop at the lowest ready task, fall back to idle
                if (ready_reg[idx_reg[IW-1:0]]) begin
                    cur_next   = idx_reg;
                    state_next = ST_DONE;
                end else if (idx_reg == LAST_IDX) begin
                    cur_next   = IDLE_TASK;
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + TW'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    run_out_next  = cur_wide[RUN_W-1:0];
                    mask_out_next = mask_wide[MASK_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cur_reg     <= IDLE_TASK;
            ready_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cur_reg     <= cur_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_out_reg  <= run_out_next;
        mask_out_reg <= mask_out_next;
    end

endmodule

/* dv/delay_tick_priority_scheduler_tb.sv */
// Self-checking testbench for delay_tick_priority_scheduler: directed rows, then
// random ops under several idle/stall phases, checked against hand-set status or a shadow scheduler.
// Depends on dtps_pkg and the delay_tick_priority_scheduler RTL.
`timescale 1ns / 1ps

module testbench;
    import dtps_pkg::*;

    localparam int NUM_TASKS   = NUM_TASKS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 350;
    localparam int DIR_ROWS    = 25;
    localparam logic [RUN_W-1:0] IDLE_TASK = RUN_W'(NUM_TASKS);

    typedef struct packed {
        logic [RUN_W-1:0]  running;
        logic [MASK_W-1:0] mask;
    } sched_status_t;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [TICKS_W-1:0]   ticks;
        logic [TASK_ID_W-1:0] id;
        logic                 typed;    // status below is fixed by hand
        logic [RUN_W-1:0]     running;
        logic [MASK_W-1:0]    mask;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op;
    logic [TICKS_W-1:0]   s_delay_ticks;
    logic [TASK_ID_W-1:0] s_task_id;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [RUN_W-1:0]     m_running_task;
    logic [MASK_W-1:0]    m_ready_mask;

    // Shadow copy of the scheduler state
    logic [MASK_W-1:0]  shadow_ready;
    logic [TICKS_W-1:0] shadow_wait [NUM_TASKS];
    logic [RUN_W-1:0]   shadow_running;

    sched_status_t pending_status [$];
    stim_row_t     stim_rows [DIR_ROWS];
    int            err_count;
    int            cycle_count = 0;
    int            send_idle_pct;
    int            recv_stall_pct;

    delay_tick_priority_scheduler #(
        .NUM_TASKS(NUM_TASKS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_delay_ticks (s_delay_ticks),
        .s_task_id     (s_task_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_running_task(m_running_task),
        .m_ready_mask  (m_ready_mask)
    );

    always #5 aclk = ~aclk;

    function automatic logic [RUN_W-1:0] lowest_ready(input logic [MASK_W-1:0] bits);
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (bits[i]) return RUN_W'(i);
        end
        return IDLE_TASK;
    endfunction

    function automatic void apply_sched_op(input logic [OP_W-1:0] op,
                                           input logic [TICKS_W-1:0] ticks,
                                           input logic [TASK_ID_W-1:0] id);
        case (op)
            OP_TICK: begin
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (shadow_wait[i] != 0) begin
                        shadow_wait[i] = shadow_wait[i] - 1'b1;
                        if (shadow_wait[i] == 0) shadow_ready[i] = 1'b1;
                    end
                end
            end
            OP_DELAY: begin
                // zero count is a no-op, no reschedule either
                if (ticks != 0) begin
                    if (shadow_running < NUM_TASKS) begin
                        shadow_ready[shadow_running] = 1'b0;
                        shadow_wait[shadow_running]  = ticks;
                    end
                    shadow_running = lowest_ready(shadow_ready);
                end
            end
            OP_READY: begin
                if (id < NUM_TASKS) shadow_ready[id] = 1'b1;
            end
            default: begin
                shadow_running = lowest_ready(shadow_ready);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task automatic send_item(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= row.op;
        s_delay_ticks <= row.ticks;
        s_task_id     <= row.id;
        do @(posedge aclk); while (!s_ready);
        apply_sched_op(row.op, row.ticks, row.id);
        if (row.typed)
            pending_status.push_back('{running: row.running, mask: row.mask});
        else
            pending_status.push_back('{running: shadow_running, mask: shadow_ready});
    endtask

    // Drop valid so the last transfer is not taken twice, then wait for results
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
    endtask

    // Check each result transfer against the oldest pending status
    always @(posedge aclk) begin
        sched_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected result, running_task", m_running_task, 0);
            end else begin
                want = pending_status.pop_front();
                if (m_running_task !== want.running)
                    report_mismatch("running_task", m_running_task, want.running);
                if (m_ready_mask !== want.mask)
                    report_mismatch("ready_mask", m_ready_mask, want.mask);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("delay_tick_priority_scheduler verification failed");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        int        r;
        int        k;

        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_TICK;
        s_delay_ticks  = '0;
        s_task_id      = '0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        shadow_ready   = '0;
        shadow_running = IDLE_TASK;
        foreach (shadow_wait[i]) shadow_wait[i] = '0;

        stim_rows = '{
            // op        ticks     id  typed run        mask
            '{OP_TICK,  16'h0000, 3'd0, 1'b1, IDLE_TASK, 8'h00},  // tick after reset
            '{OP_SCHED, 16'h0000, 3'd0, 1'b1, IDLE_TASK, 8'h00},  // nothing ready
            '{OP_DELAY, 16'h0001, 3'd0, 1'b1, IDLE_TASK, 8'h00},  // delay while idle
            '{OP_DELAY, 16'h0000, 3'd5, 1'b1, IDLE_TASK, 8'h00},  // zero delay
            '{OP_READY, 16'h0000, 3'd0, 1'b1, IDLE_TASK, 8'h01},
            '{OP_READY, 16'hFFFF, 3'd7, 1'b1, IDLE_TASK, 8'h81},
            '{OP_DELAY, 16'h0000, 3'd0, 1'b1, IDLE_TASK, 8'h81},  // zero delay, no resched
            '{OP_SCHED, 16'h0000, 3'd0, 1'b1, 4'd0,      8'h81},
            '{OP_DELAY, 16'hFFFF, 3'd0, 1'b1, 4'd7,      8'h80},  // max count
            '{OP_READY, 16'h0000, 3'd0, 1'b0, '0, '0},            // ready while counting
            '{OP_SCHED, 16'h0000, 3'd0, 1'b0, '0, '0},
            '{OP_DELAY, 16'h0001, 3'd7, 1'b0, '0, '0},
            '{OP_TICK,  16'h0000, 3'd0, 1'b0, '0, '0},            // tick does not resched
            '{OP_SCHED, 16'h0000, 3'd0, 1'b0, '0, '0},
            '{OP_DELAY, 16'h0002, 3'd0, 1'b0, '0, '0},
            '{OP_READY, 16'h0000, 3'd3, 1'b0, '0, '0},
            '{OP_SCHED, 16'h0000, 3'd0, 1'b0, '0, '0},
            '{OP_DELAY, 16'h8000, 3'd0, 1'b0, '0, '0},
            '{OP_DELAY, 16'h5555, 3'd0, 1'b0, '0, '0},
            '{OP_TICK,  16'hAAAA, 3'd2, 1'b0, '0, '0},
            '{OP_TICK,  16'h0000, 3'd0, 1'b0, '0, '0},
            '{OP_SCHED, 16'h0000, 3'd0, 1'b0, '0, '0},
            '{OP_READY, 16'h2AAA, 3'd5, 1'b0, '0, '0},
            '{OP_DELAY, 16'hAAAA, 3'd0, 1'b0, '0, '0},
            '{OP_SCHED, 16'hFFFF, 3'd7, 1'b0, '0, '0}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) send_item(stim_rows[i]);

        for (int phase = 0; phase < 4; phase++) begin
            // hold the sender until the block has delivered everything
            drain_results();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                k = $urandom_range(99);
                if (r < 35)      row.op = OP_TICK;
                else if (r < 55) row.op = OP_DELAY;
                else if (r < 75) row.op = OP_READY;
                else             row.op = OP_SCHED;
                // keep most delays short so tasks wake up again
                if (k < 60)      row.ticks = TICKS_W'($urandom_range(1, 8));
                else if (k < 70) row.ticks = '0;
                else if (k < 75) row.ticks = '1;
                else             row.ticks = TICKS_W'($urandom);
                row.id      = TASK_ID_W'($urandom_range(NUM_TASKS - 1));
                row.typed   = 1'b0;
                row.running = '0;
                row.mask    = '0;
                send_item(row);
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("delay_tick_priority_scheduler verification clean");
        end else begin
            $display("delay_tick_priority_scheduler verification failed");
        end
        $finish;
    end

endmodule
